// ===== rtl/core/sftt_pkg.sv =====
// shared types and constants for the sparse triplet transpose unit
package sftt_pkg;
   localparam int MaxEntries = 1024;
   localparam int MaxCols    = 64;
   localparam int AddrW      = $clog2(MaxEntries);
   localparam int CntW       = $clog2(MaxEntries + 1);
   localparam int ColW       = (MaxCols > 1) ? $clog2(MaxCols) : 1;
   localparam int TripW      = 48;
   localparam int QDepth     = 4;
   localparam int QAddrW     = $clog2(QDepth);

   typedef enum logic {
      KIND_LOAD = 1'b0,
      KIND_READ = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  in_row;
      logic [7:0]  in_col;
      logic signed [31:0] in_value;
      logic        in_last;
   } req_type;

   typedef struct packed {
      logic        out_valid;
      logic [7:0]  out_row;
      logic [7:0]  out_col;
      logic signed [31:0] out_value;
      logic        out_last;
      logic        out_dropped;
   } rsp_type;

   // classified item passed from front to back
   typedef struct packed {
      kind_type    kind;
      logic        keep;
      logic [7:0]  row;
      logic [7:0]  col;
      logic [31:0] value;
      logic        last;
   } cmd_type;
endpackage

// ===== rtl/core/sftt_ram.sv =====
// generic single write port ram with registered read
module sftt_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ===== rtl/core/sftt_front.sv =====
// front end: column range check and command queue
module sftt_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [6:0]               csr_wdata,
   input  logic                     csr_we,
   input  logic                     req_push,
   input  sftt_pkg::req_type        req_data,
   output logic                     req_full,
   output sftt_pkg::cmd_type        cmd_data,
   output logic                     cmd_valid,
   input  logic                     cmd_take
);
   import sftt_pkg::*;

   logic [6:0]  cols_ff;
   cmd_type     q_ff [QDepth];
   logic [QAddrW-1:0] wp_ff, rp_ff;
   logic [QAddrW:0]   cnt_ff;
   cmd_type     cmd_in;
   logic        push_ok;

   always_comb begin
      cmd_in.kind  = req_data.kind;
      cmd_in.row   = req_data.in_row;
      cmd_in.col   = req_data.in_col;
      cmd_in.value = req_data.in_value;
      cmd_in.last  = req_data.in_last;
      cmd_in.keep  = (req_data.in_col != 8'd0) && ({1'b0, cols_ff} >= req_data.in_col)
                     && (32'(req_data.in_col) <= 32'(MaxCols));
   end

   assign req_full  = (cnt_ff == (QAddrW+1)'(QDepth));
   assign push_ok   = req_push && !req_full;
   assign cmd_valid = (cnt_ff != '0);
   assign cmd_data  = q_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= 7'd64;
         wp_ff   <= '0;
         rp_ff   <= '0;
         cnt_ff  <= '0;
      end else begin
         if (csr_we) cols_ff <= csr_wdata;
         if (push_ok) wp_ff <= wp_ff + 1'b1;
         if (cmd_take) rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (QAddrW+1)'(push_ok) - (QAddrW+1)'(cmd_take);
      end
      if (push_ok) q_ff[wp_ff] <= cmd_in;
   end
endmodule

// ===== rtl/core/sftt_back.sv =====
// back end: load store, count, prefix sum, scatter and read out
module sftt_back (
   input  logic               clock,
   input  logic               reset,
   input  sftt_pkg::cmd_type  cmd_data,
   input  logic               cmd_valid,
   output logic               cmd_take,
   output sftt_pkg::rsp_type  rsp_data,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic               busy
);
   import sftt_pkg::*;

   typedef enum logic [2:0] {
      ST_RUN, ST_PREFIX, ST_SCAN, ST_SCAT, ST_PUT, ST_READ
   } state_type;

   state_type         state_ff;
   logic [CntW-1:0]   load_cnt_ff, rptr_ff, scan_ff;
   logic              ready_ff, drop_ff;
   logic [MaxCols-1:0] cnt_valid_ff;
   logic [ColW:0]     pidx_ff;
   logic [ColW-1:0]   pcol_ff;
   logic              pv_ff;
   logic [CntW-1:0]   pos_ff;
   logic              rd_last_ff;
   rsp_type           out_ff;
   logic              out_full_ff;
   // count update stage, registered in the cycle after a load that is stored
   logic              s_v_ff;
   logic [ColW-1:0]   s_col_ff;
   logic              s_cv_ff;
   // bypass for a column ram read that meets a write at the same edge
   logic              fwd_v_ff;
   logic [ColW-1:0]   fwd_addr_ff;
   logic [CntW-1:0]   fwd_data_ff;
   logic [ColW-1:0]   col_raddr_q_ff;

   logic [TripW-1:0]  ld_rd, tr_rd;
   logic              ld_we, tr_we;
   logic [AddrW-1:0]  ld_waddr, ld_raddr, tr_waddr, tr_raddr;
   logic [TripW-1:0]  ld_wdata, tr_wdata;
   logic [ColW-1:0]   col_idx, scat_idx;
   logic              is_load, accept;
   logic              col_we;
   logic [ColW-1:0]   col_waddr, col_raddr;
   logic [CntW-1:0]   col_wdata, col_rd, col_val;

   sftt_ram #(.Width(TripW), .Depth(MaxEntries)) u_loaded (
      .clock, .wr_en(ld_we), .wr_addr(ld_waddr), .wr_data(ld_wdata),
      .rd_addr(ld_raddr), .rd_data(ld_rd));
   sftt_ram #(.Width(TripW), .Depth(MaxEntries)) u_trans (
      .clock, .wr_en(tr_we), .wr_addr(tr_waddr), .wr_data(tr_wdata),
      .rd_addr(tr_raddr), .rd_data(tr_rd));
   // column counts, replaced in place by the next free slot of each column
   sftt_ram #(.Width(CntW), .Depth(MaxCols)) u_cols (
      .clock, .wr_en(col_we), .wr_addr(col_waddr), .wr_data(col_wdata),
      .rd_addr(col_raddr), .rd_data(col_rd));

   assign is_load  = (cmd_data.kind == KIND_LOAD);
   // a read needs the output slot free; a read of a stored triplet then goes through ST_READ for ram data
   assign accept   = cmd_valid && (state_ff == ST_RUN) && (is_load || !out_full_ff);
   assign cmd_take = accept;
   assign busy     = (state_ff != ST_RUN) || cmd_valid || out_full_ff;
   assign col_idx  = ColW'(cmd_data.col - 8'd1);
   assign scat_idx = ColW'(ld_rd[39:32] - 8'd1);

   assign ld_we    = accept && is_load && cmd_data.keep
                     && (load_cnt_ff < CntW'(MaxEntries) || ready_ff);
   assign ld_waddr = ready_ff ? '0 : AddrW'(load_cnt_ff);
   assign ld_wdata = {cmd_data.row, cmd_data.col, cmd_data.value};
   assign ld_raddr = AddrW'(scan_ff);
   assign tr_we    = (state_ff == ST_PUT);
   assign tr_waddr = AddrW'(col_val);
   assign tr_wdata = {ld_rd[39:32], ld_rd[47:40], ld_rd[31:0]};
   assign tr_raddr = AddrW'(rptr_ff);

   assign col_val = (fwd_v_ff && fwd_addr_ff == col_raddr_q_ff) ? fwd_data_ff : col_rd;

   always_comb begin
      case (state_ff)
         ST_PREFIX: col_raddr = pidx_ff[ColW-1:0];
         ST_SCAT:   col_raddr = scat_idx;
         default:   col_raddr = col_idx;
      endcase
   end

   always_comb begin
      col_we    = 1'b0;
      col_waddr = s_col_ff;
      col_wdata = s_cv_ff ? col_val + 1'b1 : CntW'(1);
      if (s_v_ff) begin
         col_we = 1'b1;
      end else if (state_ff == ST_PREFIX && pv_ff) begin
         col_we    = 1'b1;
         col_waddr = pcol_ff;
         col_wdata = pos_ff;
      end else if (state_ff == ST_PUT) begin
         col_we    = 1'b1;
         col_waddr = scat_idx;
         col_wdata = col_val + 1'b1;
      end
   end

   assign rsp_data  = out_ff;
   assign rsp_empty = !out_full_ff || (state_ff == ST_READ);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         load_cnt_ff  <= '0;
         rptr_ff      <= '0;
         ready_ff     <= 1'b0;
         drop_ff      <= 1'b0;
         cnt_valid_ff <= '0;
         out_full_ff  <= 1'b0;
         scan_ff      <= '0;
         pidx_ff      <= '0;
         pv_ff        <= 1'b0;
         s_v_ff       <= 1'b0;
         fwd_v_ff     <= 1'b0;
      end else begin
         s_v_ff   <= ld_we;
         fwd_v_ff <= col_we;
         if (rsp_pop && !rsp_empty) out_full_ff <= 1'b0;
         case (state_ff)
            ST_RUN: begin
               if (accept && is_load) begin
                  logic [CntW-1:0] lc;
                  logic [MaxCols-1:0] cv;
                  lc = ready_ff ? '0 : load_cnt_ff;
                  cv = ready_ff ? '0 : cnt_valid_ff;
                  if (ready_ff) begin
                     rptr_ff  <= '0;
                     ready_ff <= 1'b0;
                  end
                  if (!cmd_data.keep || lc >= CntW'(MaxEntries)) begin
                     drop_ff <= 1'b1;
                  end else begin
                     if (ready_ff) drop_ff <= 1'b0;
                     lc = lc + 1'b1;
                     cv[col_idx] = 1'b1;
                  end
                  load_cnt_ff  <= lc;
                  cnt_valid_ff <= cv;
                  if (cmd_data.last) begin
                     state_ff <= ST_PREFIX;
                     pidx_ff  <= '0;
                     pv_ff    <= 1'b0;
                     pos_ff   <= '0;
                  end
               end else if (accept) begin
                  out_ff.out_dropped <= drop_ff;
                  if (ready_ff && rptr_ff < load_cnt_ff) begin
                     rd_last_ff <= (rptr_ff + 1'b1 == load_cnt_ff);
                     rptr_ff    <= rptr_ff + 1'b1;
                     state_ff   <= ST_READ;
                  end else begin
                     out_ff.out_valid <= 1'b0;
                     out_ff.out_row   <= '0;
                     out_ff.out_col   <= '0;
                     out_ff.out_value <= '0;
                     out_ff.out_last  <= 1'b0;
                  end
                  out_full_ff <= 1'b1;
               end
            end
            ST_PREFIX: begin
               // one column a cycle, the write of each column trails its read
               pcol_ff <= pidx_ff[ColW-1:0];
               pv_ff   <= (pidx_ff != (ColW+1)'(MaxCols));
               if (pidx_ff != (ColW+1)'(MaxCols)) pidx_ff <= pidx_ff + 1'b1;
               if (pv_ff) begin
                  pos_ff <= pos_ff + (cnt_valid_ff[pcol_ff] ? col_val : '0);
                  if (pcol_ff == ColW'(MaxCols - 1)) begin
                     scan_ff  <= '0;
                     state_ff <= ST_SCAN;
                  end
               end
            end
            ST_SCAN: begin
               if (scan_ff < load_cnt_ff) begin
                  state_ff <= ST_SCAT;
               end else begin
                  ready_ff <= 1'b1;
                  state_ff <= ST_RUN;
               end
            end
            ST_SCAT: begin
               state_ff <= ST_PUT;
            end
            ST_PUT: begin
               scan_ff  <= scan_ff + 1'b1;
               state_ff <= ST_SCAN;
            end
            ST_READ: begin
               out_ff.out_valid <= 1'b1;
               out_ff.out_row   <= tr_rd[47:40];
               out_ff.out_col   <= tr_rd[39:32];
               out_ff.out_value <= tr_rd[31:0];
               out_ff.out_last  <= rd_last_ff;
               state_ff         <= ST_RUN;
            end
            default: state_ff <= ST_RUN;
         endcase
      end
      s_col_ff       <= col_idx;
      s_cv_ff        <= ready_ff ? 1'b0 : cnt_valid_ff[col_idx];
      fwd_addr_ff    <= col_waddr;
      fwd_data_ff    <= col_wdata;
      col_raddr_q_ff <= col_raddr;
   end
endmodule

// ===== rtl/core/sparse_triplet_fast_transpose_unit.sv =====
// top level of the sparse triplet transpose unit
// Loads and reads enter a four-word queue and are handled by the back end one
// at a time; a read of a stored triplet first reads the ram, then writes the
// result word. The last load of a matrix starts a prefix sum over the columns
// and a scatter of each stored triplet, during which no word leaves the queue.
// A read word waits while an earlier result is unpopped.
module sparse_triplet_fast_transpose_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [6:0]           csr_wdata,
   input  logic                 push,
   input  sftt_pkg::req_type    req_data,
   output logic                 full,
   output logic                 empty,
   input  logic                 pop,
   output sftt_pkg::rsp_type    rsp_data
);
   import sftt_pkg::*;

   cmd_type cmd_data;
   logic    cmd_valid, cmd_take, busy;

   sftt_front u_front (
      .clock, .reset, .csr_wdata, .csr_we, .req_push(push), .req_data,
      .req_full(full), .cmd_data, .cmd_valid, .cmd_take);

   sftt_back u_back (
      .clock, .reset, .cmd_data, .cmd_valid, .cmd_take, .rsp_data,
      .rsp_empty(empty), .rsp_pop(pop), .busy);

   a_take_valid: assert property (@(posedge clock) disable iff (reset)
      cmd_take |-> cmd_valid) else $error("queue taken while empty");
   a_busy_out: assert property (@(posedge clock) disable iff (reset)
      !empty |-> busy) else $error("result waiting while idle");
   a_valid_fields: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_data.out_valid) |-> (rsp_data.out_value == '0))
      else $error("empty result carries data");
endmodule

// ===== tb/tb_sparse_triplet_fast_transpose_unit.sv =====
// testbench for the sparse triplet transpose unit: directed table then random matrices
`timescale 1ns / 1ps
module tb_sparse_triplet_fast_transpose_unit;
   import sftt_pkg::*;

   localparam int WatchLimit = 40000;

   logic    clock;
   logic    reset;
   logic    csr_we;
   logic [6:0] csr_wdata;
   logic    push;
   req_type req_data;
   logic    full;
   logic    empty;
   logic    pop;
   rsp_type rsp_data;

   sparse_triplet_fast_transpose_unit DUT (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .push(push), .req_data(req_data), .full(full),
      .empty(empty), .pop(pop), .rsp_data(rsp_data)
   );

   // predictor state
   logic [7:0]  ld_row [MaxEntries];
   logic [7:0]  ld_col [MaxEntries];
   logic [31:0] ld_val [MaxEntries];
   logic [7:0]  tr_row [MaxEntries];
   logic [7:0]  tr_col [MaxEntries];
   logic [31:0] tr_val [MaxEntries];
   int unsigned col_count [MaxCols];
   int unsigned n_loaded;
   int unsigned rd_ptr;
   bit          ready;
   bit          dropped;
   int unsigned cols_setting;

   rsp_type expected_words[$];
   int      fail_count;
   int      directed_fails;
   int      idle_in;
   int      idle_out;
   int      quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void clear_matrix();
      for (int c = 0; c < MaxCols; c++) col_count[c] = 0;
      n_loaded = 0;
      rd_ptr   = 0;
      ready    = 1'b0;
      dropped  = 1'b0;
   endfunction

   function automatic void scatter_matrix();
      int unsigned next_slot [MaxCols];
      int unsigned pos;
      int unsigned ci;
      pos = 0;
      for (int c = 0; c < MaxCols; c++) begin
         next_slot[c] = pos;
         pos += col_count[c];
      end
      for (int p = 0; p < n_loaded; p++) begin
         ci = ld_col[p] - 1;
         tr_row[next_slot[ci]] = ld_col[p];
         tr_col[next_slot[ci]] = ld_row[p];
         tr_val[next_slot[ci]] = ld_val[p];
         next_slot[ci]++;
      end
      ready = 1'b1;
   endfunction

   // returns 1 and the word when the item produces a result
   function automatic bit predict_transpose(input req_type r, output rsp_type w);
      w = '0;
      if (r.kind == KIND_LOAD) begin
         if (ready) clear_matrix();
         if (r.in_col < 1 || r.in_col > cols_setting || r.in_col > MaxCols
             || n_loaded >= MaxEntries) begin
            dropped = 1'b1;
         end else begin
            ld_row[n_loaded] = r.in_row;
            ld_col[n_loaded] = r.in_col;
            ld_val[n_loaded] = r.in_value;
            col_count[r.in_col - 1]++;
            n_loaded++;
         end
         if (r.in_last) scatter_matrix();
         return 1'b0;
      end
      if (ready && rd_ptr < n_loaded) begin
         w.out_valid = 1'b1;
         w.out_row   = tr_row[rd_ptr];
         w.out_col   = tr_col[rd_ptr];
         w.out_value = tr_val[rd_ptr];
         w.out_last  = (rd_ptr + 1 == n_loaded);
         rd_ptr++;
      end
      w.out_dropped = dropped;
      return 1'b1;
   endfunction

   // push stays high after an accepted word until an idle gap, the next word or a drain
   task automatic send_item(input req_type r);
      rsp_type w;
      while ($urandom_range(99) < idle_in) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push     <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (full) @(posedge clock);
      if (predict_transpose(r, w)) expected_words.push_back(w);
   endtask

   // directed rows carry a typed expectation where it is plain to see
   task automatic send_checked(input req_type r, input rsp_type w);
      send_item(r);
      if (r.kind == KIND_READ && expected_words[$] !== w) begin
         $error("directed row: expected %h actual prediction %h", w, expected_words[$]);
         directed_fails++;
      end
   endtask

   task automatic wait_drain();
      push <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (64 + 2 * MaxEntries + 20) @(posedge clock);
   endtask

   task automatic write_cols(input int unsigned v);
      csr_we    <= 1'b1;
      csr_wdata <= v[6:0];
      @(posedge clock);
      csr_we    <= 1'b0;
      cols_setting = v;
   endtask

   function automatic req_type mk(input kind_type k, input logic [7:0] r,
                                  input logic [7:0] c, input logic [31:0] v,
                                  input logic l);
      req_type q;
      q.kind = k; q.in_row = r; q.in_col = c; q.in_value = v; q.in_last = l;
      return q;
   endfunction

   function automatic rsp_type mkw(input logic vld, input logic [7:0] r,
                                   input logic [7:0] c, input logic [31:0] v,
                                   input logic l, input logic d);
      rsp_type w;
      w.out_valid = vld; w.out_row = r; w.out_col = c; w.out_value = v;
      w.out_last = l; w.out_dropped = d;
      return w;
   endfunction

   // random matrix: loads with random content and occasional reads among them, then n_rd reads
   task automatic random_matrix(input int n, input int unsigned cmax, input bit wild,
                                input int n_rd);
      int unsigned c;
      for (int i = 0; i < n; i++) begin
         if (wild && $urandom_range(19) == 0) c = $urandom_range(255);
         else c = $urandom_range(cmax, 1);
         send_item(mk(KIND_LOAD, 8'($urandom_range(255)), c[7:0], $urandom,
                      i == n - 1));
         if ($urandom_range(29) == 0) send_item(mk(KIND_READ, 0, 0, 0, 0));
      end
      for (int i = 0; i < n_rd; i++)
         send_item(mk(KIND_READ, 8'($urandom), 8'($urandom), $urandom, 1'($urandom)));
   endtask

   // result checking
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && !empty && pop) begin
         if (expected_words.size() == 0) begin
            $error("unexpected word %h", rsp_data);
            fail_count++;
         end else begin
            e = expected_words.pop_front();
            if (rsp_data.out_valid !== e.out_valid) begin
               $error("out_valid expected %0d actual %0d", e.out_valid, rsp_data.out_valid);
               fail_count++;
            end
            if (rsp_data.out_row !== e.out_row) begin
               $error("out_row expected %0d actual %0d", e.out_row, rsp_data.out_row);
               fail_count++;
            end
            if (rsp_data.out_col !== e.out_col) begin
               $error("out_col expected %0d actual %0d", e.out_col, rsp_data.out_col);
               fail_count++;
            end
            if (rsp_data.out_value !== e.out_value) begin
               $error("out_value expected %h actual %h", e.out_value, rsp_data.out_value);
               fail_count++;
            end
            if (rsp_data.out_last !== e.out_last) begin
               $error("out_last expected %0d actual %0d", e.out_last, rsp_data.out_last);
               fail_count++;
            end
            if (rsp_data.out_dropped !== e.out_dropped) begin
               $error("out_dropped expected %0d actual %0d", e.out_dropped,
                      rsp_data.out_dropped);
               fail_count++;
            end
         end
      end
   end

   // receiver stall
   always @(posedge clock) begin
      if (reset) pop <= 1'b0;
      else pop <= ($urandom_range(99) >= idle_out);
   end

   // watchdog on accepted traffic
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > WatchLimit) begin
         $display("[sparse_triplet_fast_transpose_unit] ERROR");
         $finish;
      end
   end

   initial begin
      int nl;
      fail_count = 0;
      directed_fails = 0;
      idle_in = 12;
      idle_out = 78;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = '0;
      push = 1'b0;
      req_data = '0;
      cols_setting = 64;
      clear_matrix();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // read before any matrix, value and field extremes, bad columns, dropped last
      send_checked(mk(KIND_READ, 0, 0, 0, 0), mkw(0, 0, 0, 0, 0, 0));
      send_checked(mk(KIND_LOAD, 8'd255, 8'd64, 32'h7fffffff, 0), '0);
      send_checked(mk(KIND_LOAD, 8'd0, 8'd1, 32'h80000000, 0), '0);
      send_checked(mk(KIND_LOAD, 8'd5, 8'd0, 32'h1, 0), '0);
      send_checked(mk(KIND_LOAD, 8'd6, 8'd255, 32'hffffffff, 0), '0);
      send_checked(mk(KIND_LOAD, 8'd7, 8'd65, 32'h2, 1), '0);
      send_checked(mk(KIND_READ, 0, 0, 0, 0), mkw(1, 1, 0, 32'h80000000, 0, 1));
      send_checked(mk(KIND_READ, 0, 0, 0, 0), mkw(1, 64, 255, 32'h7fffffff, 1, 1));
      send_checked(mk(KIND_READ, 8'hff, 8'hff, 32'hffffffff, 1), mkw(0, 0, 0, 0, 0, 1));
      // empty matrix: single dropped last load
      send_checked(mk(KIND_LOAD, 8'd1, 8'd0, 32'h3, 1), '0);
      send_checked(mk(KIND_READ, 0, 0, 0, 0), mkw(0, 0, 0, 0, 0, 1));
      // stable order within a column, single-column setting
      wait_drain();
      write_cols(1);
      send_checked(mk(KIND_LOAD, 8'd9, 8'd1, 32'h11, 0), '0);
      send_checked(mk(KIND_LOAD, 8'd8, 8'd1, 32'h22, 0), '0);
      send_checked(mk(KIND_LOAD, 8'd3, 8'd2, 32'h33, 1), '0);
      send_checked(mk(KIND_READ, 0, 0, 0, 0), mkw(1, 1, 9, 32'h11, 0, 1));
      send_checked(mk(KIND_READ, 0, 0, 0, 0), mkw(1, 1, 8, 32'h22, 1, 1));
      send_checked(mk(KIND_READ, 0, 0, 0, 0), mkw(0, 0, 0, 0, 0, 1));

      // store full: one matrix of valid loads past capacity
      wait_drain();
      write_cols(64);
      random_matrix(MaxEntries + 3, 64, 1'b0, 8);

      for (int ph = 0; ph < 3; ph++) begin
         wait_drain();
         if (ph == 1) begin
            idle_in = 78; idle_out = 12;
         end else if (ph == 2) begin
            idle_in = 0; idle_out = 0;
         end
         write_cols(ph == 0 ? 127 : $urandom_range(64, 1));
         for (int m = 0; m < 7; m++) begin
            nl = $urandom_range(40, 1);
            random_matrix(nl, cols_setting > 64 ? 64 : cols_setting, 1'b1,
                          nl + $urandom_range(2));
            if (m == 3) begin
               wait_drain();
               write_cols($urandom_range(127, 1));
            end
         end
      end

      wait_drain();
      if (fail_count == 0 && directed_fails == 0)
         $display("[sparse_triplet_fast_transpose_unit] OK");
      else $display("[sparse_triplet_fast_transpose_unit] ERROR");
      $finish;
   end
endmodule

// ===== sim.f =====
rtl/core/sftt_pkg.sv
rtl/core/sftt_ram.sv
rtl/core/sftt_front.sv
rtl/core/sftt_back.sv
rtl/core/sparse_triplet_fast_transpose_unit.sv
tb/tb_sparse_triplet_fast_transpose_unit.sv
